// ===== hdl/ofbp_pkg.sv =====
// Shared types, codes and constants for the OTA frame byte parser.
package ofbp_pkg;

	localparam int          PayloadBytesDefault = 16;
	localparam logic [15:0] IdleTimeoutReset    = 16'd50000;
	localparam logic [15:0] IdleCountMax        = 16'hffff;

	localparam logic [7:0]  SYNC_FIRST   = 8'h69;
	localparam logic [7:0]  SYNC_SECOND  = 8'h96;
	localparam logic [15:0] MSG_UPDATE   = 16'h0016;
	localparam logic [7:0]  TYPE_SIZE    = 8'h00;
	localparam logic [7:0]  TYPE_DATA    = 8'h10;
	localparam logic [7:0]  TYPE_DONE    = 8'h04;
	localparam logic [7:0]  CMD_IDLE     = 8'h0e;
	localparam logic [7:0]  CMD_IDLE_ARG = 8'h00;

	localparam int HdrMiscBytes = 3;
	localparam int MsgIdBytes   = 2;
	localparam int LenBytes     = 2;
	localparam int SizeBytes    = 4;
	localparam int PageBytes    = 2;

	typedef enum logic [3:0] {
		PH_WAIT,
		PH_SYNC2,
		PH_HDRMISC,
		PH_MSGID,
		PH_LEN,
		PH_HCHK,
		PH_BCHK,
		PH_DEV,
		PH_TYPE,
		PH_SIZEPAD,
		PH_SIZE,
		PH_PAGE,
		PH_DATA,
		PH_CTRL2,
		PH_CTRL3
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE = 3'd0,
		EV_SIZE = 3'd1,
		EV_DATA = 3'd2,
		EV_DONE = 3'd3,
		EV_CTRL = 3'd4,
		EV_DROP = 3'd5
	} evt_t;

	// parser context, everything but the field counter
	typedef struct packed {
		phase_t      phase;
		logic [7:0]  header_sum;
		logic [7:0]  body_sum;
		logic [7:0]  expected_body_sum;
		logic [15:0] command_id;
		logic [31:0] size_shift;
		logic [7:0]  page_byte;
		logic [7:0]  control_first;
		logic [7:0]  control_second;
		logic [15:0] idle_count;
		logic        done_flag;
	} ctx_t;

	typedef struct packed {
		evt_t        event_res;
		logic        enter_update_mode;
		logic        enter_idle_mode;
		logic [31:0] image_size;
		logic [7:0]  page_number;
		logic [15:0] frame_message_id;
		logic        update_done_level;
		logic        payload_valid;
		logic [3:0]  payload_index;
		logic [7:0]  payload_byte;
	} result_t;

endpackage

// ===== hdl/ofbp_step.sv =====
// Next-state and result logic for one byte or idle tick.
module ofbp_step #(
	parameter int PAYLOAD_BYTES = ofbp_pkg::PayloadBytesDefault,
	parameter int FC_W          = 4
) (
	input  ofbp_pkg::ctx_t    ctx,
	input  logic [FC_W-1:0]   fc,
	input  logic              operation,
	input  logic [7:0]        data_byte,
	input  logic [15:0]       idle_timeout,
	output ofbp_pkg::ctx_t    ctx_nxt,
	output logic [FC_W-1:0]   fc_nxt,
	output ofbp_pkg::result_t res
);
	import ofbp_pkg::*;

	logic [FC_W:0]  fc_inc;
	logic [15:0]    idle_inc;
	logic [7:0]     body_add;
	logic [31:0]    size_nxt;

	assign fc_inc   = {1'b0, fc} + 1'b1;
	assign idle_inc = (ctx.idle_count != IdleCountMax) ? ctx.idle_count + 16'd1
	                                                  : ctx.idle_count;
	assign body_add = ctx.body_sum + data_byte;
	assign size_nxt = {ctx.size_shift[23:0], data_byte};

	always_comb begin
		ctx_nxt = ctx;
		fc_nxt  = fc;
		res     = '0;
		res.event_res = EV_NONE;

		if (operation) begin
			ctx_nxt.idle_count = idle_inc;
			if (ctx.phase != PH_WAIT && idle_inc > idle_timeout) begin
				ctx_nxt.phase      = PH_WAIT;
				fc_nxt             = '0;
				ctx_nxt.idle_count = '0;
				res.event_res      = EV_DROP;
			end
		end else begin
			ctx_nxt.idle_count = '0;
			case (ctx.phase)
				PH_WAIT: begin
					if (data_byte == SYNC_FIRST) begin
						ctx_nxt.header_sum = data_byte;
						ctx_nxt.phase      = PH_SYNC2;
					end else begin
						ctx_nxt.control_first = data_byte;
						ctx_nxt.phase         = PH_CTRL2;
					end
				end
				PH_SYNC2: begin
					fc_nxt = '0;
					if (data_byte == SYNC_SECOND) begin
						ctx_nxt.header_sum = ctx.header_sum + data_byte;
						ctx_nxt.phase      = PH_HDRMISC;
					end else begin
						ctx_nxt.phase = PH_WAIT;
						res.event_res = EV_DROP;
					end
				end
				PH_HDRMISC: begin
					ctx_nxt.header_sum = ctx.header_sum + data_byte;
					fc_nxt = FC_W'(fc_inc);
					if (fc_inc >= (FC_W+1)'(HdrMiscBytes)) begin
						fc_nxt        = '0;
						ctx_nxt.phase = PH_MSGID;
					end
				end
				PH_MSGID: begin
					ctx_nxt.header_sum = ctx.header_sum + data_byte;
					ctx_nxt.command_id = {ctx.command_id[7:0], data_byte};
					fc_nxt = FC_W'(fc_inc);
					if (fc_inc >= (FC_W+1)'(MsgIdBytes)) begin
						fc_nxt        = '0;
						ctx_nxt.phase = PH_LEN;
					end
				end
				PH_LEN: begin
					ctx_nxt.header_sum = ctx.header_sum + data_byte;
					fc_nxt = FC_W'(fc_inc);
					if (fc_inc >= (FC_W+1)'(LenBytes)) begin
						fc_nxt        = '0;
						ctx_nxt.phase = PH_HCHK;
					end
				end
				PH_HCHK: begin
					if (data_byte == ctx.header_sum) begin
						ctx_nxt.phase = PH_BCHK;
					end else begin
						ctx_nxt.phase = PH_WAIT;
						fc_nxt        = '0;
						res.event_res = EV_DROP;
					end
				end
				PH_BCHK: begin
					ctx_nxt.expected_body_sum = data_byte;
					ctx_nxt.body_sum          = '0;
					ctx_nxt.phase             = PH_DEV;
				end
				PH_DEV: begin
					ctx_nxt.body_sum = body_add;
					ctx_nxt.phase    = PH_TYPE;
				end
				PH_TYPE: begin
					ctx_nxt.body_sum  = body_add;
					fc_nxt            = '0;
					ctx_nxt.done_flag = 1'b0;
					if (data_byte == TYPE_SIZE) begin
						ctx_nxt.size_shift = '0;
						ctx_nxt.phase      = PH_SIZEPAD;
					end else if (data_byte == TYPE_DATA) begin
						ctx_nxt.phase = PH_PAGE;
					end else if (data_byte == TYPE_DONE) begin
						ctx_nxt.done_flag = 1'b1;
						ctx_nxt.phase     = PH_WAIT;
						res.event_res     = EV_DONE;
					end else begin
						ctx_nxt.phase = PH_WAIT;
						res.event_res = EV_DROP;
					end
				end
				PH_SIZEPAD: begin
					ctx_nxt.body_sum = body_add;
					ctx_nxt.phase    = PH_SIZE;
				end
				PH_SIZE: begin
					ctx_nxt.body_sum   = body_add;
					ctx_nxt.size_shift = size_nxt;
					fc_nxt = FC_W'(fc_inc);
					if (fc_inc >= (FC_W+1)'(SizeBytes)) begin
						if (body_add == ctx.expected_body_sum) begin
							res.event_res         = EV_SIZE;
							res.image_size        = size_nxt;
							res.enter_update_mode = (ctx.command_id == MSG_UPDATE);
						end else begin
							res.event_res = EV_DROP;
						end
						ctx_nxt.phase = PH_WAIT;
						fc_nxt        = '0;
					end
				end
				PH_PAGE: begin
					ctx_nxt.body_sum = body_add;
					if (fc == '0)
						ctx_nxt.page_byte = data_byte;
					fc_nxt = FC_W'(fc_inc);
					if (fc_inc >= (FC_W+1)'(PageBytes)) begin
						fc_nxt        = '0;
						ctx_nxt.phase = PH_DATA;
					end
				end
				PH_DATA: begin
					ctx_nxt.body_sum  = body_add;
					res.payload_valid = 1'b1;
					res.payload_index = 4'(fc);
					res.payload_byte  = data_byte;
					fc_nxt = FC_W'(fc_inc);
					if (fc_inc >= (FC_W+1)'(PAYLOAD_BYTES)) begin
						res.event_res = (body_add == ctx.expected_body_sum) ? EV_DATA
						                                                    : EV_DROP;
						ctx_nxt.phase = PH_WAIT;
						fc_nxt        = '0;
					end
				end
				PH_CTRL2: begin
					ctx_nxt.control_second = data_byte;
					ctx_nxt.phase          = PH_CTRL3;
				end
				PH_CTRL3: begin
					if (8'(ctx.control_first + ctx.control_second) == data_byte) begin
						res.event_res       = EV_CTRL;
						res.enter_idle_mode = (ctx.control_first == CMD_IDLE) &&
						                      (ctx.control_second == CMD_IDLE_ARG);
					end else begin
						res.event_res = EV_DROP;
					end
					ctx_nxt.phase = PH_WAIT;
					fc_nxt        = '0;
				end
				default: begin
					ctx_nxt.phase = PH_WAIT;
					fc_nxt        = '0;
				end
			endcase
		end

		// status fields follow the context after this step
		res.page_number       = ctx_nxt.page_byte;
		res.frame_message_id  = ctx_nxt.command_id;
		res.update_done_level = ctx_nxt.done_flag;
	end

endmodule

// ===== hdl/ota_frame_byte_parser.sv =====
// Top level of the OTA frame byte parser: input register, step logic, result register.
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid, in_ready, operation, data_byte  | in_valid & in_ready
//  out     | out_valid, out_ready, result fields       | out_valid & out_ready
//  cfg     | cfg_wr_en, cfg_wr_data                    | cfg_wr_en (no wait)
//
//  One item per clock sustained while the output is not stalled; each input transfer
//  fills the input register, and out_valid rises when the result register takes the step.
//  The step logic runs when the input register holds an item and the result
//  register is empty or being emptied; the parser context updates on that edge.
//  A stalled output holds its result and the input register absorbs one more
//  item before in_ready falls.
//  arst_n clears the parser context, idle_timeout to 50000 and both valid flags.
module ota_frame_byte_parser #(
	parameter int PAYLOAD_BYTES = ofbp_pkg::PayloadBytesDefault
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  data_byte,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  event_res,
	output logic        enter_update_mode,
	output logic        enter_idle_mode,
	output logic [31:0] image_size,
	output logic [7:0]  page_number,
	output logic [15:0] frame_message_id,
	output logic        update_done_level,
	output logic        payload_valid,
	output logic [3:0]  payload_index,
	output logic [7:0]  payload_byte,

	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);
	import ofbp_pkg::*;

	// field counter must reach PAYLOAD_BYTES-1 and at least 3
	localparam int FC_W = (PAYLOAD_BYTES > 4) ? $clog2(PAYLOAD_BYTES) : 2;

	logic            valid_s1;
	logic            op_s1;
	logic [7:0]      byte_s1;
	logic            advance;

	ctx_t            ctx_q, ctx_nxt;
	logic [FC_W-1:0] fc_q, fc_nxt;
	logic [15:0]     idle_timeout_q;

	result_t         res_nxt;
	result_t         res_q;
	logic            out_valid_q;

	// step fires when the result slot is free or draining
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= operation;
			byte_s1 <= data_byte;
		end
	end

	// configuration register; the user must write it only while idle, the block itself does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= IdleTimeoutReset;
		end else if (cfg_wr_en) begin
			idle_timeout_q <= cfg_wr_data;
		end
	end

	ofbp_step #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.FC_W          (FC_W)
	) u_step (
		.ctx          (ctx_q),
		.fc           (fc_q),
		.operation    (op_s1),
		.data_byte    (byte_s1),
		.idle_timeout (idle_timeout_q),
		.ctx_nxt      (ctx_nxt),
		.fc_nxt       (fc_nxt),
		.res          (res_nxt)
	);

	// parser context; all-zero is the waiting phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '0;
			fc_q  <= '0;
		end else if (advance) begin
			ctx_q <= ctx_nxt;
			fc_q  <= fc_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid         = out_valid_q;
	assign event_res         = res_q.event_res;
	assign enter_update_mode = res_q.enter_update_mode;
	assign enter_idle_mode   = res_q.enter_idle_mode;
	assign image_size        = res_q.image_size;
	assign page_number       = res_q.page_number;
	assign frame_message_id  = res_q.frame_message_id;
	assign update_done_level = res_q.update_done_level;
	assign payload_valid     = res_q.payload_valid;
	assign payload_index     = res_q.payload_index;
	assign payload_byte      = res_q.payload_byte;

	// update request only comes with a good size frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.enter_update_mode |-> res_q.event_res == EV_SIZE)
		else $error("update request without size event");

	// idle request only comes with a good control frame
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.enter_idle_mode |-> res_q.event_res == EV_CTRL)
		else $error("idle request without control event");

	// payload bytes only carry none, data-ok or drop events
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.payload_valid |->
			res_q.event_res == EV_NONE || res_q.event_res == EV_DATA ||
			res_q.event_res == EV_DROP)
		else $error("payload byte with wrong event");

	// a timeout leaves the parser waiting with the idle count cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && op_s1 && ctx_q.phase != PH_WAIT && res_nxt.event_res == EV_DROP |=>
			ctx_q.phase == PH_WAIT && ctx_q.idle_count == '0 && fc_q == '0)
		else $error("timeout did not return to wait");

	// a result taken while no new one is made empties the slot
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_ready && !advance |=> !out_valid_q)
		else $error("result repeated");

endmodule
